// ===== sv/prow_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prow_pkg
// Shared types and constants of the planar raster-op write path: request and
// response payloads, access modes and register offsets.
// ----------------------------------------------------------------------------
package prow_pkg;

   localparam int WordBits = 16;
   localparam int CodeBits = 4;
   localparam int AddrBits = 5;
   localparam int DataBits = 32;

   typedef logic [WordBits-1:0] word_type;

   typedef struct packed {
      logic [3:0] plane_index;
      word_type   source_latch;
      word_type   dest_word;
      word_type   bus_mask;
   } req_type;

   typedef struct packed {
      word_type new_word;
      logic     plane_enabled;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_CONST  = 2'd0,
      MODE_PIXEL  = 2'd1,
      MODE_BIT0   = 2'd2,
      MODE_SHIFT  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_ROP_CODES     = 3'd0,
      REG_ROP_ENABLE    = 3'd1,
      REG_ACCESS_MODE   = 3'd2,
      REG_SHIFT_COUNT   = 3'd3,
      REG_WRITE_PROTECT = 3'd4,
      REG_PLANE_MASK    = 3'd5
   } reg_index_type;

endpackage
`default_nettype wire

// ===== sv/planar_raster_op_write_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_raster_op_write_core
// Write path of a planar frame-buffer raster-op unit: forms the source word,
// applies the per-plane boolean function and merges under the write masks.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle, set by the input and result registers.
// busy stays low; the response strobe lasts one cycle and cannot be stalled.
// Reset: synchronous; configuration registers and valid flags clear, access mode returns to shifted word.
// ----------------------------------------------------------------------------
module planar_raster_op_write_core
   import prow_pkg::*;
#(
   parameter int PLANES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire req_type             req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [AddrBits-1:0] paddr,
   input  wire logic [DataBits-1:0] pwdata,
   output logic [DataBits-1:0]      prdata,
   output logic                     pready
);

   localparam logic [4:0] PlaneLimit = 5'(PLANES);

   // configuration registers
   logic [31:0]   rop_codes_ff;
   logic          rop_enable_ff;
   mode_type      access_mode_ff;
   logic [4:0]    shift_count_ff;
   word_type      write_protect_ff;
   logic [7:0]    plane_mask_ff;

   logic          csr_write;
   reg_index_type csr_index;

   // pipeline registers
   logic    req_valid_ff;
   req_type req_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   // datapath
   logic                plane_ok;
   word_type            src;
   logic [2*WordBits-1:0] wide;
   logic [2*WordBits-1:0] wide_shifted;
   logic [CodeBits-1:0] code;
   word_type            func;
   word_type            merged;
   word_type            protect;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rop_codes_ff     <= '0;
         rop_enable_ff    <= 1'b0;
         access_mode_ff   <= MODE_SHIFT;
         shift_count_ff   <= '0;
         write_protect_ff <= '0;
         plane_mask_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ROP_CODES:     rop_codes_ff     <= pwdata;
            REG_ROP_ENABLE:    rop_enable_ff    <= pwdata[0];
            REG_ACCESS_MODE:   access_mode_ff   <= mode_type'(pwdata[1:0]);
            REG_SHIFT_COUNT:   shift_count_ff   <= pwdata[4:0];
            REG_WRITE_PROTECT: write_protect_ff <= pwdata[WordBits-1:0];
            REG_PLANE_MASK:    plane_mask_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROP_CODES:     prdata = rop_codes_ff;
         REG_ROP_ENABLE:    prdata = {31'd0, rop_enable_ff};
         REG_ACCESS_MODE:   prdata = {30'd0, access_mode_ff};
         REG_SHIFT_COUNT:   prdata = {27'd0, shift_count_ff};
         REG_WRITE_PROTECT: prdata = {16'd0, write_protect_ff};
         REG_PLANE_MASK:    prdata = {24'd0, plane_mask_ff};
         default:           prdata = '0;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // source word
   assign wide = shift_count_ff[4] ? {req_ff.source_latch, 16'd0}
                                   : {16'd0, req_ff.source_latch};
   assign wide_shifted = wide >> shift_count_ff[3:0];

   always_comb begin
      unique case (access_mode_ff)
         MODE_CONST: src = '1;
         MODE_PIXEL: src = {WordBits{req_ff.source_latch[req_ff.plane_index]}};
         MODE_BIT0:  src = {WordBits{req_ff.source_latch[0]}};
         MODE_SHIFT: src = wide_shifted[WordBits-1:0];
         default:    src = '0;
      endcase
   end

   // raster function, code bit chosen by {~s, ~d}
   assign plane_ok = {1'b0, req_ff.plane_index} < PlaneLimit;
   assign code     = plane_ok ? rop_codes_ff[{req_ff.plane_index[2:0], 2'b00} +: CodeBits]
                              : '0;

   always_comb begin
      for (int i = 0; i < WordBits; i++) begin
         func[i] = code[{~src[i], ~req_ff.dest_word[i]}];
      end
   end

   assign merged  = rop_enable_ff ? func : src;
   assign protect = write_protect_ff | ~req_ff.bus_mask;

   always_comb begin
      rsp_in.new_word      = (req_ff.dest_word & protect) | (merged & ~protect);
      rsp_in.plane_enabled = plane_ok && !plane_mask_ff[req_ff.plane_index[2:0]];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // every accepted request gives one response through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response missing after request");

   // protected or uncovered bits keep the destination
   a_protect: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (((rsp_data.new_word ^ $past(req_ff.dest_word))
                      & $past(write_protect_ff | ~req_ff.bus_mask)) == '0))
      else $error("protected bit changed");

   // a plane beyond the plane count is never selected
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.plane_enabled) |->
         ({1'b0, $past(req_ff.plane_index)} < PlaneLimit))
      else $error("out-of-range plane selected");

   // no response without a request in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_valid_ff))
      else $error("response without request");

endmodule
`default_nettype wire
